FILE: hdl/gbs_pkg.sv
// Shared constants and types of the Gaussian background subtractor.
`default_nettype none

package gbs_pkg;

   localparam int DEF_MAX_PIXELS  = 65536;
   localparam int DEF_MAX_TRAIN   = 255;
   localparam int DEF_QUEUE_DEPTH = 4;

   localparam int PIXEL_W     = 8;
   localparam int POS_W       = 16;
   localparam int TRAIN_W     = 8;
   localparam int FP_W        = 17;
   localparam int NSIG_W      = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;
   localparam int MEAN_MAX    = 255;

   localparam logic [TRAIN_W-1:0] TRAIN_FRAMES_RST = 8'd100;
   localparam logic [FP_W-1:0]    FRAME_PIXELS_RST = 17'd65536;
   localparam logic [NSIG_W-1:0]  NSIGMA_Q4_RST    = 8'd32;

   localparam logic [CSR_INDEX_W-1:0] CSR_TRAIN_FRAMES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_PIXELS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NSIGMA_Q4    = 2'd2;

   typedef enum logic [1:0] {
      OP_INIT,
      OP_ACC,
      OP_SUM,
      OP_DET
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [PIXEL_W-1:0]   pixel;
      logic [POS_W-1:0]     position;
      logic                 last;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } front_status_type;

   typedef struct packed {
      logic idle;
      logic result_load;
   } back_status_type;

endpackage

`default_nettype wire

FILE: hdl/gbs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module gbs_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 65536
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AW-1:0]        rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/gbs_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module gbs_div #(
   parameter int DIVIDEND_W = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [DIVIDEND_W-1:0]         dividend,
   input  wire logic [gbs_pkg::TRAIN_W-1:0]   divisor,
   output logic                               done,
   output logic      [DIVIDEND_W-1:0]         quotient
);

   localparam int DV_W  = gbs_pkg::TRAIN_W;
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DV_W-1:0]       rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DV_W:0]         shifted;
   logic [DV_W+1:0]       diff;
   logic                  ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      ge      = !diff[DV_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DV_W-1:0] : shifted[DV_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: hdl/gbs_front.sv
// Front end: accepts pixels, tracks frame and position, classifies and queues them.
`default_nettype none

module gbs_front #(
   parameter int MAX_PIXELS  = gbs_pkg::DEF_MAX_PIXELS,
   parameter int MAX_TRAIN   = gbs_pkg::DEF_MAX_TRAIN,
   parameter int QUEUE_DEPTH = gbs_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [gbs_pkg::PIXEL_W-1:0]       req_pixel,
   input  wire logic [gbs_pkg::TRAIN_W-1:0]       train_frames,
   input  wire logic [gbs_pkg::FP_W-1:0]          frame_pixels,
   input  wire logic                              pop,
   output gbs_pkg::item_type                      head_item,
   output logic      [ADDR_W-1:0]                 head_addr,
   output logic                                   head_valid,
   output logic      [gbs_pkg::TRAIN_W-1:0]       n_eff,
   output gbs_pkg::front_status_type              status
);

   localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int LIM_W  = $clog2(MAX_PIXELS + 1);
   localparam int CMP_W  = (LIM_W > gbs_pkg::FP_W) ? LIM_W : gbs_pkg::FP_W;
   localparam int FC_W   = $clog2(MAX_TRAIN + 2);
   localparam int FCC_W  = (FC_W > gbs_pkg::TRAIN_W) ? FC_W : gbs_pkg::TRAIN_W;
   localparam int QA_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

   logic [ADDR_W-1:0]       pc_ff, pc_in;
   logic [FC_W-1:0]         fc_ff, fc_in;
   logic [QA_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]         cnt_ff, cnt_in;
   gbs_pkg::item_type       q_item [QUEUE_DEPTH];
   logic [ADDR_W-1:0]       q_addr [QUEUE_DEPTH];

   logic [CMP_W-1:0]        fp_ext, max_ext, lim, lim_m1, pos_ext;
   logic [FCC_W-1:0]        fc_ext, n_ext;
   logic                    accept, last;
   gbs_pkg::item_type       new_item;

   always_comb begin
      if (train_frames == '0) begin
         n_eff = gbs_pkg::TRAIN_W'(1);
      end else if (int'(train_frames) > MAX_TRAIN) begin
         n_eff = gbs_pkg::TRAIN_W'(MAX_TRAIN);
      end else begin
         n_eff = train_frames;
      end

      fp_ext  = CMP_W'(frame_pixels);
      max_ext = CMP_W'(MAX_PIXELS);
      lim     = (fp_ext == '0 || fp_ext > max_ext) ? max_ext : fp_ext;
      lim_m1  = lim - CMP_W'(1);
      pos_ext = CMP_W'(pc_ff);
      last    = (pos_ext >= lim_m1);

      fc_ext = FCC_W'(fc_ff);
      n_ext  = FCC_W'(n_eff);

      new_item.pixel    = req_pixel;
      new_item.position = pos_ext[gbs_pkg::POS_W-1:0];
      new_item.last     = last;
      if (fc_ext < n_ext) begin
         new_item.op = (fc_ext == '0) ? gbs_pkg::OP_INIT : gbs_pkg::OP_ACC;
      end else if (fc_ext == n_ext) begin
         new_item.op = gbs_pkg::OP_SUM;
      end else begin
         new_item.op = gbs_pkg::OP_DET;
      end
   end

   assign req_stall = (cnt_ff == QC_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pc_in     = pc_ff;
      fc_in     = fc_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         pc_in = last ? '0 : pc_ff + ADDR_W'(1);
         if (last && fc_ext <= n_ext) begin
            fc_in = fc_ff + FC_W'(1);
         end
         wr_ptr_in = (wr_ptr_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QA_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QA_W'(1);
      end
      case ({accept, pop})
         2'b10:   cnt_in = cnt_ff + QC_W'(1);
         2'b01:   cnt_in = cnt_ff - QC_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         fc_ff     <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         pc_ff     <= pc_in;
         fc_ff     <= fc_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_item[wr_ptr_ff] <= new_item;
         q_addr[wr_ptr_ff] <= pc_ff;
      end
   end

   assign head_item    = q_item[rd_ptr_ff];
   assign head_addr    = q_addr[rd_ptr_ff];
   assign head_valid   = (cnt_ff != '0);
   assign status.empty = (cnt_ff == '0);
   assign status.full  = req_stall;

endmodule

`default_nettype wire

FILE: hdl/gbs_back.sv
// Back end: model store access, mean and deviation update, and the foreground test.
`default_nettype none

module gbs_back #(
   parameter int MAX_PIXELS = gbs_pkg::DEF_MAX_PIXELS,
   parameter int MAX_TRAIN  = gbs_pkg::DEF_MAX_TRAIN
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              head_valid,
   input  wire gbs_pkg::item_type                 head_item,
   input  wire logic [ADDR_W-1:0]                 head_addr,
   output logic                                   pop,
   input  wire logic [gbs_pkg::TRAIN_W-1:0]       n_eff,
   input  wire logic [gbs_pkg::NSIG_W-1:0]        nsigma_q4,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_foreground,
   output logic      [gbs_pkg::POS_W-1:0]         rsp_pixel_position,
   output logic                                   rsp_last_in_frame,
   output gbs_pkg::back_status_type               status
);

   localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int PW     = gbs_pkg::PIXEL_W;
   localparam int NW     = gbs_pkg::TRAIN_W;
   localparam int TB     = $clog2(MAX_TRAIN + 1);
   localparam int SUM_W  = PW + TB;
   localparam int SQ_W   = 2 * PW + TB;
   localparam int WORD_W = SUM_W + SQ_W;
   localparam int NSQ_W  = 2 * gbs_pkg::NSIG_W;
   localparam int RHS_W  = NSQ_W + SQ_W;
   localparam int LHS_W  = NW + 2 * PW;
   localparam int CMPD_W = (LHS_W + PW > RHS_W) ? LHS_W + PW : RHS_W;
   localparam int MS_W   = PW + SUM_W;
   localparam int MM_W   = 2 * PW;
   localparam int NMM_W  = NW + MM_W;
   localparam int EW     = ((SQ_W > NMM_W) ? SQ_W : NMM_W) + 2;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_EXEC = 8'b0000_0010,
      S_DIV  = 8'b0000_0100,
      S_MUL1 = 8'b0000_1000,
      S_MUL2 = 8'b0001_0000,
      S_WB   = 8'b0010_0000,
      S_DMUL = 8'b0100_0000,
      S_DOUT = 8'b1000_0000
   } back_state_type;

   back_state_type       st_ff, st_in;
   gbs_pkg::item_type    item_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [PW-1:0]        m_ff;
   logic [MS_W-1:0]      ms_ff;
   logic [MM_W-1:0]      mm_ff;
   logic [NMM_W-1:0]     nmm_ff;
   logic [2*PW-1:0]      dif2_ff;
   logic [RHS_W-1:0]     rhs_ff;
   logic [LHS_W-1:0]     lhs_ff;
   logic [NSQ_W-1:0]     nsq_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 fg_ff;
   logic [gbs_pkg::POS_W-1:0] pos_ff;
   logic                 last_ff;

   logic [WORD_W-1:0]    rd_data, wr_data;
   logic                 wr_en;
   logic [SUM_W-1:0]     rd_sum, acc_sum, quotient;
   logic [SQ_W-1:0]      rd_sq, acc_sq, d_store;
   logic [2*PW-1:0]      px_sq;
   logic [PW-1:0]        m_det, dif;
   logic [EW-1:0]        d_full;
   logic                 div_start, div_done, load, out_free, fg_calc;

   assign rd_sum = rd_data[WORD_W-1 -: SUM_W];
   assign rd_sq  = rd_data[SQ_W-1:0];

   assign pop       = (st_ff == S_IDLE) && head_valid;
   assign div_start = (st_ff == S_EXEC) && (item_ff.op == gbs_pkg::OP_SUM);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = (st_ff == S_DOUT) && out_free;

   always_comb begin
      px_sq   = (2*PW)'(item_ff.pixel) * (2*PW)'(item_ff.pixel);
      acc_sum = (item_ff.op == gbs_pkg::OP_INIT) ? SUM_W'(item_ff.pixel)
                                                 : rd_sum + SUM_W'(item_ff.pixel);
      acc_sq  = (item_ff.op == gbs_pkg::OP_INIT) ? SQ_W'(px_sq) : rd_sq + SQ_W'(px_sq);

      m_det = (rd_sum > SUM_W'(gbs_pkg::MEAN_MAX)) ? PW'(gbs_pkg::MEAN_MAX) : rd_sum[PW-1:0];
      dif   = (item_ff.pixel > m_det) ? item_ff.pixel - m_det : m_det - item_ff.pixel;

      d_full  = EW'(sq_ff) + EW'(nmm_ff) - EW'({ms_ff, 1'b0});
      d_store = d_full[EW-1] ? '0 : d_full[SQ_W-1:0];

      fg_calc = CMPD_W'({lhs_ff, PW'(0)}) > CMPD_W'(rhs_ff);

      wr_en   = ((st_ff == S_EXEC) &&
                 (item_ff.op == gbs_pkg::OP_INIT || item_ff.op == gbs_pkg::OP_ACC)) ||
                (st_ff == S_WB);
      wr_data = (st_ff == S_WB) ? {SUM_W'(m_ff), d_store} : {acc_sum, acc_sq};
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (head_valid) begin
               st_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (item_ff.op) inside
               gbs_pkg::OP_INIT, gbs_pkg::OP_ACC: st_in = S_IDLE;
               gbs_pkg::OP_SUM:                   st_in = S_DIV;
               default:                           st_in = S_DMUL;
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               st_in = S_MUL1;
            end
         end
         S_MUL1: st_in = S_MUL2;
         S_MUL2: st_in = S_WB;
         S_WB:   st_in = S_IDLE;
         S_DMUL: st_in = S_DOUT;
         S_DOUT: begin
            if (out_free) begin
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nsq_ff <= NSQ_W'(nsigma_q4) * NSQ_W'(nsigma_q4);
      if (pop) begin
         item_ff <= head_item;
         addr_ff <= head_addr;
      end
      if (st_ff == S_EXEC) begin
         sum_ff  <= rd_sum;
         sq_ff   <= rd_sq;
         dif2_ff <= (2*PW)'(dif) * (2*PW)'(dif);
         rhs_ff  <= RHS_W'(nsq_ff) * RHS_W'(rd_sq);
      end
      if (div_done) begin
         m_ff <= (quotient > SUM_W'(gbs_pkg::MEAN_MAX)) ? PW'(gbs_pkg::MEAN_MAX)
                                                        : quotient[PW-1:0];
      end
      if (st_ff == S_MUL1) begin
         ms_ff <= MS_W'(m_ff) * MS_W'(sum_ff);
         mm_ff <= MM_W'(m_ff) * MM_W'(m_ff);
      end
      if (st_ff == S_MUL2) begin
         nmm_ff <= NMM_W'(n_eff) * NMM_W'(mm_ff);
      end
      if (st_ff == S_DMUL) begin
         lhs_ff <= LHS_W'(n_eff) * LHS_W'(dif2_ff);
      end
      if (load) begin
         fg_ff   <= fg_calc;
         pos_ff  <= item_ff.position;
         last_ff <= item_ff.last;
      end
   end

   gbs_div #(
      .DIVIDEND_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_sum),
      .divisor  (n_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   gbs_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_PIXELS)
   ) u_model_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_en   (pop),
      .rd_addr (head_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_foreground     = fg_ff;
   assign rsp_pixel_position = pos_ff;
   assign rsp_last_in_frame  = last_ff;
   assign status.idle        = (st_ff == S_IDLE);
   assign status.result_load = load;

endmodule

`default_nettype wire

FILE: hdl/gaussian_background_subtractor.sv
// Single-Gaussian background subtractor top level with configuration registers.
//
// Pixels arrive in raster order on the req_ channel and land in a four-entry queue, so a
// short burst is taken one pixel per cycle while the queue has room; behind it a single
// sequencer works on one pixel at a time against a per-pixel model memory. During the
// train_frames training frames a pixel is read and its sum and sum of squares updated
// in a read-modify-write; it produces no result. In the frame after training the
// divider forms the mean one quotient bit per cycle, followed by three multiply and
// write-back steps; no result is produced. In every later frame a pixel goes through a
// read, two multiply stages and a compare, and yields one result with its foreground flag,
// raster position and end-of-frame marker, held in an output register until transferred.
// The model memory is not cleared after reset; training overwrites every entry of the
// frame before it is used. Configuration writes are accepted in every cycle and must only
// be issued while no pixel is in flight.
`default_nettype none

module gaussian_background_subtractor #(
   parameter int MAX_PIXELS  = gbs_pkg::DEF_MAX_PIXELS,
   parameter int MAX_TRAIN   = gbs_pkg::DEF_MAX_TRAIN,
   parameter int QUEUE_DEPTH = gbs_pkg::DEF_QUEUE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [gbs_pkg::PIXEL_W-1:0]         req_pixel,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_foreground,
   output logic      [gbs_pkg::POS_W-1:0]           rsp_pixel_position,
   output logic                                     rsp_last_in_frame,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [gbs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [gbs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

   logic [gbs_pkg::TRAIN_W-1:0] train_frames_ff, train_frames_in;
   logic [gbs_pkg::FP_W-1:0]    frame_pixels_ff, frame_pixels_in;
   logic [gbs_pkg::NSIG_W-1:0]  nsigma_q4_ff, nsigma_q4_in;

   gbs_pkg::item_type           head_item;
   logic [ADDR_W-1:0]           head_addr;
   logic                        head_valid, pop;
   logic [gbs_pkg::TRAIN_W-1:0] n_eff;
   gbs_pkg::front_status_type   fstat;
   gbs_pkg::back_status_type    bstat;

   assign csr_ready = 1'b1;

   always_comb begin
      train_frames_in = train_frames_ff;
      frame_pixels_in = frame_pixels_ff;
      nsigma_q4_in    = nsigma_q4_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gbs_pkg::CSR_TRAIN_FRAMES: train_frames_in = csr_wdata[gbs_pkg::TRAIN_W-1:0];
            gbs_pkg::CSR_FRAME_PIXELS: frame_pixels_in = csr_wdata[gbs_pkg::FP_W-1:0];
            gbs_pkg::CSR_NSIGMA_Q4:    nsigma_q4_in    = csr_wdata[gbs_pkg::NSIG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         train_frames_ff <= gbs_pkg::TRAIN_FRAMES_RST;
         frame_pixels_ff <= gbs_pkg::FRAME_PIXELS_RST;
         nsigma_q4_ff    <= gbs_pkg::NSIGMA_Q4_RST;
      end else begin
         train_frames_ff <= train_frames_in;
         frame_pixels_ff <= frame_pixels_in;
         nsigma_q4_ff    <= nsigma_q4_in;
      end
   end

   gbs_front #(
      .MAX_PIXELS  (MAX_PIXELS),
      .MAX_TRAIN   (MAX_TRAIN),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel    (req_pixel),
      .train_frames (train_frames_ff),
      .frame_pixels (frame_pixels_ff),
      .pop          (pop),
      .head_item    (head_item),
      .head_addr    (head_addr),
      .head_valid   (head_valid),
      .n_eff        (n_eff),
      .status       (fstat)
   );

   gbs_back #(
      .MAX_PIXELS (MAX_PIXELS),
      .MAX_TRAIN  (MAX_TRAIN)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_item          (head_item),
      .head_addr          (head_addr),
      .pop                (pop),
      .n_eff              (n_eff),
      .nsigma_q4          (nsigma_q4_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_foreground     (rsp_foreground),
      .rsp_pixel_position (rsp_pixel_position),
      .rsp_last_in_frame  (rsp_last_in_frame),
      .status             (bstat)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fstat.empty)
      else $error("Queue popped while empty.");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !fstat.empty)
      else $error("Accepted pixel did not reach the queue.");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> bstat.idle)
      else $error("Queue popped while the back end was busy.");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(bstat.result_load))
      else $error("Result appeared without a detection step.");

endmodule

`default_nettype wire

FILE: tb/tb_gaussian_background_subtractor.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Gaussian background subtractor with directed and random frames.
module tb_gaussian_background_subtractor;
   import gbs_pkg::*;

   localparam int DRAIN_CYCLES   = 256;
   localparam int STALL_LIMIT    = 4000;
   localparam int MODEL_DEPTH    = DEF_MAX_PIXELS;
   localparam int USED_POSITIONS = 11;
   localparam int RANDOM_ITEMS   = 600;
   localparam longint SPREAD_MAX = 64'd4294967295;

   typedef struct packed {
      logic             foreground;
      logic [POS_W-1:0] position;
      logic             last;
   } detection_t;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_foreground;
   logic [POS_W-1:0]       rsp_pixel_position;
   logic                   rsp_last_in_frame;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic [31:0]        bg_level [MODEL_DEPTH];
   logic [31:0]        bg_spread [MODEL_DEPTH];
   int unsigned        frames_done = 0;
   int unsigned        pixel_index = 0;
   logic [TRAIN_W-1:0] cfg_train   = TRAIN_FRAMES_RST;
   logic [FP_W-1:0]    cfg_pixels  = FRAME_PIXELS_RST;
   logic [NSIG_W-1:0]  cfg_nsigma  = NSIGMA_Q4_RST;
   logic [PIXEL_W-1:0] backdrop [USED_POSITIONS];
   detection_t         pending_detections [$];

   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int hold_request    = 0;
   int hold_left       = 0;
   int failures        = 0;
   int pixels_sent     = 0;
   int results_checked = 0;
   int foreground_seen = 0;
   int configs_applied = 0;
   int quiet_cycles    = 0;

   gaussian_background_subtractor u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel          (req_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_foreground     (rsp_foreground),
      .rsp_pixel_position (rsp_pixel_position),
      .rsp_last_in_frame  (rsp_last_in_frame),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned train_count();
      return (cfg_train == 0) ? 1 : cfg_train;
   endfunction

   task automatic predict_pixel(input logic [PIXEL_W-1:0] px);
      longint            n, lim, s, q, m, d;
      longint unsigned   mean, dif, lhs, rhs;
      logic [POS_W-1:0]  idx;
      logic              last;
      detection_t        want;
      n    = train_count();
      lim  = (cfg_pixels == 0 || cfg_pixels > MODEL_DEPTH) ? MODEL_DEPTH : cfg_pixels;
      idx  = pixel_index[POS_W-1:0];
      last = (pixel_index >= lim - 1);
      if (frames_done < n) begin
         if (frames_done == 0) begin
            bg_level[idx]  = 32'(px);
            bg_spread[idx] = 32'(px) * 32'(px);
         end else begin
            bg_level[idx]  = bg_level[idx] + 32'(px);
            bg_spread[idx] = bg_spread[idx] + 32'(px) * 32'(px);
         end
      end else if (frames_done == n) begin
         s = bg_level[idx];
         q = bg_spread[idx];
         m = s / n;
         if (m > MEAN_MAX) m = MEAN_MAX;
         d = q - 2 * m * s + n * m * m;
         if (d < 0) d = 0;
         if (d > SPREAD_MAX) d = SPREAD_MAX;
         bg_level[idx]  = m[31:0];
         bg_spread[idx] = d[31:0];
      end else begin
         mean = (bg_level[idx] > MEAN_MAX) ? MEAN_MAX : bg_level[idx];
         dif  = (px > mean) ? px - mean : mean - px;
         lhs  = 64'(256) * 64'(n) * dif * dif;
         rhs  = 64'(cfg_nsigma) * 64'(cfg_nsigma) * 64'(bg_spread[idx]);
         want.foreground = (lhs > rhs);
         want.position   = idx;
         want.last       = last;
         pending_detections.push_back(want);
      end
      if (last) begin
         pixel_index = 0;
         if (frames_done <= n) frames_done++;
      end else begin
         pixel_index++;
      end
   endtask

   function automatic logic [PIXEL_W-1:0] scene_pixel();
      int level;
      level = backdrop[pixel_index % USED_POSITIONS];
      if ($urandom_range(19) < 3) return $urandom_range(255);
      level = level + int'($urandom_range(12)) - 6;
      if (level < 0) level = 0;
      if (level > 255) level = 255;
      return level[PIXEL_W-1:0];
   endfunction

   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      int gap;
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      predict_pixel(px);
      pixels_sent++;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_detections.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] train, pixels, nsigma);
      logic [CSR_INDEX_W-1:0] index_list [3];
      logic [CSR_DATA_W-1:0]  value_list [3];
      index_list = '{CSR_TRAIN_FRAMES, CSR_FRAME_PIXELS, CSR_NSIGMA_Q4};
      value_list = '{train, pixels, nsigma};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= index_list[i];
         csr_wdata <= value_list[i];
         do @(posedge clock); while (!csr_ready);
         case (index_list[i])
            CSR_TRAIN_FRAMES: begin
               cfg_train = value_list[i][TRAIN_W-1:0];
            end
            CSR_FRAME_PIXELS: begin
               cfg_pixels = value_list[i][FP_W-1:0];
            end
            CSR_NSIGMA_Q4: begin
               cfg_nsigma = value_list[i][NSIG_W-1:0];
            end
            default: begin
            end
         endcase
      end
      csr_valid <= 1'b0;
      configs_applied++;
   endtask

   // The first frame covers every position that later frames use, so no
   // model entry is read before it has been written.
   task automatic test_training_extremes();
      logic [PIXEL_W-1:0] frame_zero [USED_POSITIONS];
      frame_zero = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd85, 8'd170, 8'd15, 8'd240,
                     8'd127, 8'd64};
      backdrop = frame_zero;
      send_idle_pct = 0;
      stall_pct = 0;
      configure(0, 17'd65536, NSIGMA_Q4_RST);
      for (int i = 0; i < 4; i++) send_pixel(frame_zero[i]);
      drain_results();
      configure(0, 0, NSIGMA_Q4_RST);
      for (int i = 4; i < 7; i++) send_pixel(frame_zero[i]);
      drain_results();
      configure(0, 17'h1FFFF, NSIGMA_Q4_RST);
      for (int i = 7; i < 10; i++) send_pixel(frame_zero[i]);
      drain_results();
      configure(0, 4, 16);
      send_pixel(frame_zero[10]);
   endtask

   task automatic test_first_detection();
      for (int i = 0; i < 4; i++) send_pixel($urandom_range(255));
      send_pixel(backdrop[0]);
      send_pixel(backdrop[1]);
      send_pixel(backdrop[2] - 8'd1);
      send_pixel(backdrop[3] + 8'd1);
   endtask

   task automatic test_backpressure();
      drain_results();
      send_idle_pct = 0;
      stall_pct = 0;
      configure(1, USED_POSITIONS, 32);
      hold_request = 400;
      repeat (40) send_pixel(scene_pixel());
      drain_results();
   endtask

   task automatic run_scene(input int phase);
      logic [CSR_DATA_W-1:0] train, pixels, nsigma;
      int unsigned           n_eff;
      drain_results();
      case (phase)
         0: begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         1: begin
            send_idle_pct = 83;
            stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            stall_pct = 83;
         end
         default: begin
            send_idle_pct = 17;
            stall_pct = 17;
         end
      endcase
      case ($urandom_range(3))
         0: pixels = 1;
         1: pixels = USED_POSITIONS;
         default: pixels = $urandom_range(USED_POSITIONS, 1);
      endcase
      case ($urandom_range(5))
         0: nsigma = 0;
         1: nsigma = 255;
         2: nsigma = $urandom_range(255);
         default: nsigma = $urandom_range(64, 8);
      endcase
      if ($urandom_range(3) == 0 && frames_done + 3 <= DEF_MAX_TRAIN) begin
         train = frames_done + $urandom_range(3);
      end else begin
         train = $urandom_range(frames_done - 1, 0);
      end
      configure(train, pixels, nsigma);
      n_eff = train_count();
      while (frames_done <= n_eff) send_pixel(scene_pixel());
      repeat ($urandom_range(4, 1) * pixels) send_pixel(scene_pixel());
   endtask

   task automatic test_random_scenes();
      int first;
      int scene;
      first = pixels_sent;
      scene = 0;
      while (pixels_sent - first < RANDOM_ITEMS) begin
         run_scene(scene % 4);
         scene++;
      end
   endtask

   task automatic test_long_training();
      drain_results();
      send_idle_pct = 17;
      stall_pct = 17;
      configure(255, 1, 255);
      while (frames_done <= DEF_MAX_TRAIN) send_pixel(scene_pixel());
      repeat (12) send_pixel(scene_pixel());
   endtask

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      detection_t want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (rsp_foreground) foreground_seen++;
            if (pending_detections.size() == 0) begin
               failures++;
               $error("result with no pixel waiting for it, position %0d", rsp_pixel_position);
            end else begin
               want = pending_detections.pop_front();
               if (rsp_foreground !== want.foreground) begin
                  failures++;
                  $error("foreground: expected %0d, actual %0d", want.foreground,
                         rsp_foreground);
               end
               if (rsp_pixel_position !== want.position) begin
                  failures++;
                  $error("pixel_position: expected %0d, actual %0d", want.position,
                         rsp_pixel_position);
               end
               if (rsp_last_in_frame !== want.last) begin
                  failures++;
                  $error("last_in_frame: expected %0d, actual %0d", want.last,
                         rsp_last_in_frame);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
                     STALL_LIMIT, pending_detections.size());
            $display("[gaussian_background_subtractor] ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_training_extremes();
      test_first_detection();
      test_backpressure();
      test_random_scenes();
      test_long_training();
      drain_results();
      $display("Sent %0d pixels under %0d register settings; checked %0d results, %0d foreground.",
               pixels_sent, configs_applied, results_checked, foreground_seen);
      $display("Frame sizes 1 to %0d and the out-of-range sizes, 1 to 255 training frames.",
               USED_POSITIONS);
      if (failures == 0) begin
         $display("[gaussian_background_subtractor] OK");
      end else begin
         $display("[gaussian_background_subtractor] ERROR");
      end
      $finish;
   end

endmodule
